// File: design/line_point_generator_top_macros.svh
// Assertion macros for the line point generator.
// Included by line_point_generator_top.sv; empty bodies when SYNTH is defined.
`ifndef LINE_POINT_GENERATOR_TOP_MACROS_SVH
`define LINE_POINT_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTH
`define LPG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line point generator check failed");
`define LPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line point generator check failed");
`else
`define LPG_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LPG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/lpg_pkg.sv
// Shared constants and types for the line point generator.
// No dependencies.
`default_nettype none
package lpg_pkg;
    localparam int COORD_BITS_DEF = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } t_lpg_state;
endpackage
`default_nettype wire

// File: design/lpg_if.sv
// Handshake interfaces: segment requests in, line points out.
// Depends on lpg_pkg for the default coordinate width.
`default_nettype none
interface lpg_seg_if #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y, input end_x,
                    input end_y, output ready);
endinterface

interface lpg_pt_if #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  is_last;

    modport source (output valid, output point_x, output point_y, output is_last,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input is_last,
                    output ready);
endinterface
`default_nettype wire

// File: design/line_point_generator_top.sv
// Line point generator: rasterizes one segment per item into grid points.
// An accepted segment passes the setup state; the run state registers points.
// Throughput: one point per cycle from a single decision-variable adder;
// unless stalled; major+1 points per segment (major = larger axis distance).
// Reset (synchronous, active low) returns the sequencer to idle and drops
// any pending point. Depends on lpg_pkg, lpg_if and the macros header.
`default_nettype none
`include "line_point_generator_top_macros.svh"
module line_point_generator_top #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lpg_seg_if.sink     i_seg,
    lpg_pt_if.source    o_pt
);
    import lpg_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int PW = COORD_BITS + 3;

    t_lpg_state r_state, n_state;

    // segment setup
    logic [CB-1:0] r_sx, r_sy, r_dx, r_dy;
    logic          r_x_dec, r_y_dec;

    // iteration state
    logic                 r_x_major;
    logic [CB-1:0]        r_maj_pos, r_min_pos, r_cnt;
    logic                 r_maj_dec, r_min_dec;
    logic signed [PW-1:0] r_p, r_inc_lo, r_inc_hi;

    // output register
    logic          r_out_valid;
    logic [CB-1:0] r_pt_x, r_pt_y;
    logic          r_pt_last;

    logic                 seg_take;
    logic                 run_adv;
    logic                 out_take;
    logic                 x_major;
    logic [CB-1:0]        major, minor;
    logic [CB-1:0]        dx, dy;
    logic signed [PW-1:0] inc_lo, inc_hi;
    logic                 p_step;
    logic [CB-1:0]        n_min_pos;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (seg_take) n_state = ST_SETUP;
            ST_SETUP: n_state = ST_RUN;
            ST_RUN:   if (run_adv && (r_cnt == '0)) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_seg.ready = 1'b0;
        run_adv     = 1'b0;
        case (r_state)
            ST_IDLE:  i_seg.ready = 1'b1;
            ST_SETUP: ;
            ST_RUN:   run_adv = !r_out_valid || o_pt.ready;
            default:  ;
        endcase
    end

    assign seg_take = i_seg.valid && i_seg.ready;
    assign out_take = r_out_valid && o_pt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- datapath ----------------
    assign dx = (i_seg.end_x >= i_seg.start_x) ? i_seg.end_x - i_seg.start_x
                                               : i_seg.start_x - i_seg.end_x;
    assign dy = (i_seg.end_y >= i_seg.start_y) ? i_seg.end_y - i_seg.start_y
                                               : i_seg.start_y - i_seg.end_y;

    assign x_major = (r_dy <= r_dx);
    assign major   = x_major ? r_dx : r_dy;
    assign minor   = x_major ? r_dy : r_dx;
    assign inc_lo  = {{(PW-CB-1){1'b0}}, minor, 1'b0};
    assign inc_hi  = inc_lo - {{(PW-CB-1){1'b0}}, major, 1'b0};

    // positive decision value: take the diagonal step
    assign p_step    = !r_p[PW-1] && (r_p != '0);
    assign n_min_pos = p_step ? (r_min_dec ? r_min_pos - 1'b1 : r_min_pos + 1'b1)
                              : r_min_pos;

    always_ff @(posedge i_clk) begin
        if (seg_take) begin
            r_sx    <= i_seg.start_x;
            r_sy    <= i_seg.start_y;
            r_dx    <= dx;
            r_dy    <= dy;
            r_x_dec <= (i_seg.end_x < i_seg.start_x);
            r_y_dec <= (i_seg.end_y < i_seg.start_y);
        end
        if (r_state == ST_SETUP) begin
            r_x_major <= x_major;
            r_maj_pos <= x_major ? r_sx : r_sy;
            r_min_pos <= x_major ? r_sy : r_sx;
            r_maj_dec <= x_major ? r_x_dec : r_y_dec;
            r_min_dec <= x_major ? r_y_dec : r_x_dec;
            r_inc_lo  <= inc_lo;
            r_inc_hi  <= inc_hi;
            r_p       <= inc_hi;
            r_cnt     <= major;
        end else if (run_adv) begin
            r_p       <= r_p + (p_step ? r_inc_hi : r_inc_lo);
            r_min_pos <= n_min_pos;
            r_maj_pos <= r_maj_dec ? r_maj_pos - 1'b1 : r_maj_pos + 1'b1;
            r_cnt     <= r_cnt - 1'b1;
            r_pt_x    <= r_x_major ? r_maj_pos : n_min_pos;
            r_pt_y    <= r_x_major ? n_min_pos : r_maj_pos;
            r_pt_last <= (r_cnt == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (run_adv) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_pt.valid   = r_out_valid;
    assign o_pt.point_x = r_pt_x;
    assign o_pt.point_y = r_pt_y;
    assign o_pt.is_last = r_pt_last;

    // ---------------- checks ----------------
    `LPG_ASSERT_NEXT(a_seg_to_setup, i_clk, i_rst_n, seg_take, r_state == ST_SETUP)
    `LPG_ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, run_adv && r_cnt == '0, r_pt_last)
    `LPG_ASSERT_SAME(a_p_no_wrap, i_clk, i_rst_n, r_state == ST_RUN, r_p[PW-1] == r_p[PW-2])
    `LPG_ASSERT_NEXT(a_adv_gives_point, i_clk, i_rst_n, run_adv, r_out_valid)
endmodule
`default_nettype wire
